FILE: hdl/signal_pending_dispatch_top_defines.svh
// ----------------------------------------------------------------------------
// Signal pending dispatch assertion macros
// Concurrent assertion helpers for the top level of the signal dispatcher.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PENDING_DISPATCH_TOP_DEFINES_SVH
`define SIGNAL_PENDING_DISPATCH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside of reset.
`define SPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define SPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SPD_ASSERT(lbl, prop, msg)
`define SPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hdl/spd_pkg.sv
// ----------------------------------------------------------------------------
// Signal pending dispatch package
// Opcodes, result codes, signal constants and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

  localparam int SignalCount = 64;
  localparam int MaskW       = 64;
  localparam int SigW        = 6;
  localparam int SnW         = 7;
  localparam int AddrW       = 64;
  localparam int TableDepth  = 64;

  localparam logic [SigW-1:0] SigKill = 6'd9;
  localparam logic [SigW-1:0] SigChld = 6'd17;
  localparam logic [SigW-1:0] SigStop = 6'd19;

  // Signals whose default action dumps core: 4, 5, 6, 7, 8, 11, 24, 25.
  localparam logic [MaskW-1:0] CoreMask = 64'h0000_0000_0300_09F0;
  // Pending bits that check and deliver can see.
  localparam logic [MaskW-1:0] VisMask = {MaskW{1'b1}} >> (MaskW - SignalCount);

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_LOOKUP   = 3'd1,
    OP_RAISE    = 3'd2,
    OP_CHECK    = 3'd3,
    OP_DELIVER  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_RANGE     = 3'd1,
    RC_KILLSTOP  = 3'd2,
    RC_NONE      = 3'd3,
    RC_IGNORED   = 3'd4,
    RC_HANDLER   = 3'd5,
    RC_TERM      = 3'd6,
    RC_TERM_CORE = 3'd7
  } rc_t;

  // Where the handler field of a result comes from.
  typedef enum logic [1:0] {
    HS_ZERO  = 2'd0,
    HS_ADDR  = 2'd1,
    HS_TABLE = 2'd2
  } hsrc_t;

  // Decisions of the dispatch stage for one item.
  typedef struct packed {
    rc_t              code;
    logic [MaskW-1:0] pend;
    hsrc_t            hsrc;
    logic             ignored;
    logic             ready;
    logic [SigW-1:0]  taken;
    logic [SigW-1:0]  rd_addr;
    logic             wr_en;
    logic [MaskW-1:0] valid_nxt;
    logic [MaskW-1:0] ignore_nxt;
  } ctl_t;

  // Index of the lowest set bit; zero for an empty mask.
  function automatic logic [SigW-1:0] lowest_index(input logic [MaskW-1:0] m);
    logic [SigW-1:0] idx;
    idx = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SigW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/spd_table.sv
// ----------------------------------------------------------------------------
// Signal pending dispatch handler table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_table (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [spd_pkg::SigW-1:0]    wr_addr,
  input  wire logic [spd_pkg::AddrW-1:0]   wr_data,
  input  wire logic                        rd_en,
  input  wire logic [spd_pkg::SigW-1:0]    rd_addr,
  output      logic [spd_pkg::AddrW-1:0]   rd_data
);

  logic [spd_pkg::AddrW-1:0] mem [spd_pkg::TableDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds when the read is not enabled, so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/spd_dispatch.sv
// ----------------------------------------------------------------------------
// Signal pending dispatch decision logic
// Decodes one registered item against the valid and ignore bits.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_dispatch (
  input  wire logic [2:0]                   opcode,
  input  wire logic [spd_pkg::SnW-1:0]      signal_number,
  input  wire logic [spd_pkg::AddrW-1:0]    handler_address,
  input  wire logic                         ignore_flag,
  input  wire logic [spd_pkg::MaskW-1:0]    pending_in,
  input  wire logic [spd_pkg::MaskW-1:0]    valid_bits,
  input  wire logic [spd_pkg::MaskW-1:0]    ignore_bits,
  output      spd_pkg::ctl_t                ctl
);

  logic                       in_range;
  logic [spd_pkg::SigW-1:0]   s;
  logic [spd_pkg::MaskW-1:0]  s_bit;
  logic [spd_pkg::MaskW-1:0]  vis;
  logic [spd_pkg::MaskW-1:0]  stop_set;
  logic [spd_pkg::MaskW-1:0]  sel;
  logic [spd_pkg::MaskW-1:0]  low_bit;
  logic [spd_pkg::MaskW-1:0]  below;
  logic [spd_pkg::SigW-1:0]   g;
  logic [spd_pkg::MaskW-1:0]  pend_chk;

  assign in_range = signal_number < spd_pkg::SnW'(spd_pkg::SignalCount);
  assign s        = signal_number[spd_pkg::SigW-1:0];
  assign s_bit    = spd_pkg::MaskW'(1) << s;
  assign vis      = pending_in & spd_pkg::VisMask;

  // Check stops at the first non-ignored signal, or at an ignored child signal.
  assign stop_set = (vis & ~ignore_bits) |
                    (vis & ignore_bits & (spd_pkg::MaskW'(1) << spd_pkg::SigChld));
  assign sel      = (opcode == spd_pkg::OP_CHECK) ? stop_set : vis;
  assign low_bit  = sel & (~sel + spd_pkg::MaskW'(1));
  assign below    = low_bit - spd_pkg::MaskW'(1);
  assign g        = spd_pkg::lowest_index(sel);
  // Every visible signal below the stop point is ignored and gets dropped.
  assign pend_chk = pending_in & ~(vis & below);

  always_comb begin
    ctl            = '0;
    ctl.code       = spd_pkg::RC_OK;
    ctl.pend       = pending_in;
    ctl.hsrc       = spd_pkg::HS_ZERO;
    ctl.rd_addr    = s;
    ctl.valid_nxt  = valid_bits;
    ctl.ignore_nxt = ignore_bits;
    unique case (opcode)
      spd_pkg::OP_REGISTER: begin
        if (!in_range) begin
          ctl.code = spd_pkg::RC_RANGE;
        end else if (s == spd_pkg::SigKill || s == spd_pkg::SigStop) begin
          ctl.code = spd_pkg::RC_KILLSTOP;
        end else begin
          ctl.wr_en      = 1'b1;
          ctl.valid_nxt  = (handler_address != '0) ? (valid_bits | s_bit)
                                                   : (valid_bits & ~s_bit);
          ctl.ignore_nxt = ignore_flag ? (ignore_bits | s_bit) : (ignore_bits & ~s_bit);
          ctl.hsrc       = spd_pkg::HS_ADDR;
          ctl.ignored    = ignore_flag;
        end
      end
      spd_pkg::OP_LOOKUP: begin
        if (!in_range) begin
          ctl.code = spd_pkg::RC_RANGE;
        end else begin
          ctl.hsrc    = valid_bits[s] ? spd_pkg::HS_TABLE : spd_pkg::HS_ZERO;
          ctl.ignored = ignore_bits[s];
        end
      end
      spd_pkg::OP_RAISE: begin
        if (!in_range) begin
          ctl.code = spd_pkg::RC_RANGE;
        end else begin
          ctl.pend = pending_in | s_bit;
        end
      end
      spd_pkg::OP_CHECK: begin
        if (sel == '0) begin
          ctl.code = spd_pkg::RC_NONE;
          ctl.pend = pending_in & ~vis;
        end else begin
          ctl.taken = g;
          if ((low_bit & ignore_bits) != '0) begin
            ctl.code = spd_pkg::RC_IGNORED;
            ctl.pend = pend_chk & ~low_bit;
          end else begin
            ctl.ready = 1'b1;
            ctl.pend  = pend_chk;
          end
        end
      end
      spd_pkg::OP_DELIVER: begin
        if (sel == '0) begin
          ctl.code = spd_pkg::RC_NONE;
        end else begin
          ctl.pend    = pending_in & ~low_bit;
          ctl.taken   = g;
          ctl.rd_addr = g;
          if ((low_bit & ignore_bits) != '0) begin
            ctl.code = spd_pkg::RC_IGNORED;
          end else if ((low_bit & valid_bits) != '0) begin
            ctl.code      = spd_pkg::RC_HANDLER;
            ctl.hsrc      = spd_pkg::HS_TABLE;
            ctl.valid_nxt = valid_bits & ~low_bit;
          end else if ((low_bit & spd_pkg::CoreMask) != '0) begin
            ctl.code = spd_pkg::RC_TERM_CORE;
          end else begin
            ctl.code = spd_pkg::RC_TERM;
          end
        end
      end
      default: begin
        ctl.code = spd_pkg::RC_RANGE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/signal_pending_dispatch_top.sv
// ----------------------------------------------------------------------------
// Signal pending dispatch top level
// Per-signal handler table and five-opcode dispatcher on stream channels.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result side is not stalled and
// returns exactly one result per item. An item is first captured in an input
// register; the dispatch logic (a 64-bit lowest-set-bit search and mask
// update) decides the result and, as the item moves into the result register,
// updates the handler-valid and ignore bits, writes the handler table and
// issues the table read, whose registered data joins the result register. The
// throughput of one item per cycle is set by that single dispatch stage and by
// the one read and one write port of the handler table. Results leave in order;
// when the result side stalls, one further item is still accepted and held in
// the input register. Handler table contents are not cleared at reset: entry
// data is used only after its valid bit has been set by a register command.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signal_pending_dispatch_top_defines.svh"

module signal_pending_dispatch_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // opcode[2:0], signal_number[9:3], handler_address[73:10], ignore_flag[74],
  // pending_in[138:75], zero fill[143:139]
  input  wire logic [143:0] in_tdata,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // result_code[2:0], pending_out[66:3], handler_out[130:67], ignored_out[131],
  // signal_ready[132], signal_taken[138:133], zero fill[143:139]
  output      logic [143:0] out_tdata
);

  // Input register stage.
  logic                        v1_r;
  logic [2:0]                  op_r;
  logic [spd_pkg::SnW-1:0]     sn_r;
  logic [spd_pkg::AddrW-1:0]   haddr_r;
  logic                        iflag_r;
  logic [spd_pkg::MaskW-1:0]   pend_r;

  // Result register stage.
  logic                        v2_r;
  spd_pkg::rc_t                code_r;
  logic [spd_pkg::MaskW-1:0]   pend_out_r;
  logic [spd_pkg::AddrW-1:0]   haddr_out_r;
  spd_pkg::hsrc_t              hsrc_r;
  logic                        ignored_r;
  logic                        ready_r;
  logic [spd_pkg::SigW-1:0]    taken_r;

  // Per-signal state.
  logic [spd_pkg::MaskW-1:0]   hvalid_r;
  logic [spd_pkg::MaskW-1:0]   ign_r;

  spd_pkg::ctl_t               ctl;
  logic [spd_pkg::AddrW-1:0]   rd_data;
  logic [spd_pkg::AddrW-1:0]   handler_out;
  logic                        adv2;
  logic                        fire1;
  logic                        in_fire;

  // The result register frees up when empty or when its result is taken.
  assign adv2      = !v2_r || out_tready;
  assign fire1     = v1_r && adv2;
  assign in_tready = !v1_r || adv2;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_fire) begin
      v1_r <= 1'b1;
    end else if (fire1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_tdata[2:0];
      sn_r    <= in_tdata[9:3];
      haddr_r <= in_tdata[73:10];
      iflag_r <= in_tdata[74];
      pend_r  <= in_tdata[138:75];
    end
  end

  spd_dispatch u_dispatch (
    .opcode          (op_r),
    .signal_number   (sn_r),
    .handler_address (haddr_r),
    .ignore_flag     (iflag_r),
    .pending_in      (pend_r),
    .valid_bits      (hvalid_r),
    .ignore_bits     (ign_r),
    .ctl             (ctl)
  );

  spd_table u_table (
    .clk     (clk),
    .wr_en   (fire1 && ctl.wr_en),
    .wr_addr (sn_r[spd_pkg::SigW-1:0]),
    .wr_data (haddr_r),
    .rd_en   (fire1),
    .rd_addr (ctl.rd_addr),
    .rd_data (rd_data)
  );

  // State bits change only when the item actually moves into the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
      ign_r    <= '0;
    end else if (fire1) begin
      hvalid_r <= ctl.valid_nxt;
      ign_r    <= ctl.ignore_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (fire1) begin
      v2_r <= 1'b1;
    end else if (out_tready) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1) begin
      code_r      <= ctl.code;
      pend_out_r  <= ctl.pend;
      haddr_out_r <= haddr_r;
      hsrc_r      <= ctl.hsrc;
      ignored_r   <= ctl.ignored;
      ready_r     <= ctl.ready;
      taken_r     <= ctl.taken;
    end
  end

  always_comb begin
    unique case (hsrc_r)
      spd_pkg::HS_ADDR:  handler_out = haddr_out_r;
      spd_pkg::HS_TABLE: handler_out = rd_data;
      default:           handler_out = '0;
    endcase
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = {5'b0, taken_r, ready_r, ignored_r, handler_out, pend_out_r,
                       code_r};

  // Kill and stop can never gain a handler or be ignored.
  `SPD_ASSERT(a_killstop_fixed,
    !hvalid_r[spd_pkg::SigKill] && !hvalid_r[spd_pkg::SigStop] &&
    !ign_r[spd_pkg::SigKill] && !ign_r[spd_pkg::SigStop],
    "kill or stop entry was modified")
  // A handler run always returns a nonzero address from the table.
  `SPD_ASSERT(a_handler_nonzero,
    v2_r && code_r == spd_pkg::RC_HANDLER |-> handler_out != '0,
    "run handler returned a zero address")
  // A ready check reports success.
  `SPD_ASSERT(a_ready_ok,
    v2_r && ready_r |-> code_r == spd_pkg::RC_OK,
    "signal_ready set with a non-ok code")
  // A delivery that finds a signal clears exactly one pending bit.
  `SPD_ASSERT(a_deliver_one,
    fire1 && op_r == spd_pkg::OP_DELIVER && ctl.code != spd_pkg::RC_NONE |->
    $countones(ctl.pend) + 1 == $countones(pend_r),
    "deliver did not clear exactly one pending bit")
  // After reset, both the input and the result register are empty.
  `SPD_ASSERT_ALWAYS(a_no_result_in_reset,
    !rst_n |=> !v1_r && !v2_r,
    "pipeline not empty after reset")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Signal pending dispatch testbench
// Drives register, lookup, raise, check, deliver and unused-opcode items into
// the dispatcher, predicts results from its own copy of the handler table, valid
// bits and ignore bits, and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes past deliver are not decoded by the block and must come back as a
  // range error with the mask untouched.
  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;

  localparam int RandomItems = 1500;
  localparam int DrainAfter  = 750;
  localparam int CycleLimit  = 400000;
  localparam int TailCycles  = 10;

  // One input item, as the fields of in_tdata.
  typedef struct packed {
    logic [2:0]                op;
    logic [spd_pkg::SnW-1:0]   sn;
    logic [spd_pkg::AddrW-1:0] haddr;
    logic                      ign;
    logic [spd_pkg::MaskW-1:0] pend;
  } sig_item_t;

  // One result item, as the fields of out_tdata.
  typedef struct packed {
    logic [2:0]                code;
    logic [spd_pkg::MaskW-1:0] pend;
    logic [spd_pkg::AddrW-1:0] hout;
    logic                      ign;
    logic                      ready;
    logic [spd_pkg::SigW-1:0]  taken;
  } sig_result_t;

  // A row of the directed table. Rows marked known carry a result typed in by
  // hand; all others take the predicted result.
  typedef struct {
    sig_item_t   it;
    bit          known;
    sig_result_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;

  // Predicted state of the dispatcher.
  logic [spd_pkg::AddrW-1:0] sig_handler [spd_pkg::TableDepth];
  logic [spd_pkg::MaskW-1:0] sig_has_handler;
  logic [spd_pkg::MaskW-1:0] sig_ignored;

  // Results still owed by the block, oldest first.
  sig_result_t outcome_q [$];
  dir_row_t    dir_rows [$];

  // The pending mask the task would carry into its next item. Feeding it back
  // lets raise, check and deliver act on one evolving task.
  logic [spd_pkg::MaskW-1:0] chain_mask = '0;

  bit no_gaps = 1'b0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int code_hist [8];

  signal_pending_dispatch_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // A hung handshake must not hang the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Computes the result of one item and applies its side effects to the
  // predicted handler table, valid bits and ignore bits.
  function automatic sig_result_t dispatch_outcome(input sig_item_t it);
    sig_result_t               r;
    logic [spd_pkg::SigW-1:0]  s;
    logic                      in_range;
    logic [spd_pkg::MaskW-1:0] vis;
    r = '0;
    r.pend = it.pend;
    s = it.sn[spd_pkg::SigW-1:0];
    in_range = (it.sn < spd_pkg::SignalCount);
    case (it.op)
      spd_pkg::OP_REGISTER: begin
        if (!in_range) begin
          r.code = spd_pkg::RC_RANGE;
        end else if (s == spd_pkg::SigKill || s == spd_pkg::SigStop) begin
          r.code = spd_pkg::RC_KILLSTOP;
        end else begin
          sig_handler[s] = it.haddr;
          sig_has_handler[s] = (it.haddr != '0);
          sig_ignored[s] = it.ign;
          r.hout = it.haddr;
          r.ign = it.ign;
        end
      end
      spd_pkg::OP_LOOKUP: begin
        if (!in_range) begin
          r.code = spd_pkg::RC_RANGE;
        end else begin
          r.hout = sig_has_handler[s] ? sig_handler[s] : '0;
          r.ign = sig_ignored[s];
        end
      end
      spd_pkg::OP_RAISE: begin
        if (!in_range) begin
          r.code = spd_pkg::RC_RANGE;
        end else begin
          r.pend[s] = 1'b1;
        end
      end
      spd_pkg::OP_CHECK: begin
        r.code = spd_pkg::RC_NONE;
        // Walk up from the lowest pending signal, dropping ignored ones. An
        // ignored child signal is dropped too but ends the walk.
        for (int g = 0; g < spd_pkg::MaskW; g++) begin
          if (r.pend[g] && spd_pkg::VisMask[g]) begin
            if (!sig_ignored[g]) begin
              r.code = spd_pkg::RC_OK;
              r.ready = 1'b1;
              r.taken = spd_pkg::SigW'(g);
              break;
            end
            r.pend[g] = 1'b0;
            if (g == spd_pkg::SigChld) begin
              r.code = spd_pkg::RC_IGNORED;
              r.taken = spd_pkg::SigW'(g);
              break;
            end
          end
        end
      end
      spd_pkg::OP_DELIVER: begin
        vis = r.pend & spd_pkg::VisMask;
        r.code = spd_pkg::RC_NONE;
        for (int g = 0; g < spd_pkg::MaskW; g++) begin
          if (vis[g]) begin
            r.pend[g] = 1'b0;
            r.taken = spd_pkg::SigW'(g);
            if (sig_ignored[g]) begin
              r.code = spd_pkg::RC_IGNORED;
            end else if (sig_has_handler[g]) begin
              // Handlers are one-shot: taking one disarms it.
              r.code = spd_pkg::RC_HANDLER;
              r.hout = sig_handler[g];
              sig_has_handler[g] = 1'b0;
            end else begin
              r.code = spd_pkg::CoreMask[g] ? spd_pkg::RC_TERM_CORE : spd_pkg::RC_TERM;
            end
            break;
          end
        end
      end
      default: begin
        r.code = spd_pkg::RC_RANGE;
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op,
                                  input logic [spd_pkg::SnW-1:0] sn,
                                  input logic [spd_pkg::AddrW-1:0] ha, input logic fl,
                                  input logic [spd_pkg::MaskW-1:0] pd,
                                  input bit known = 1'b0,
                                  input logic [2:0] code = spd_pkg::RC_OK,
                                  input logic [spd_pkg::MaskW-1:0] po = '0,
                                  input logic [spd_pkg::SigW-1:0] tk = '0);
    dir_row_t row;
    row.it = '{op: op, sn: sn, haddr: ha, ign: fl, pend: pd};
    row.known = known;
    row.want = '{code: code, pend: po, hout: '0, ign: 1'b0, ready: 1'b0, taken: tk};
    dir_rows.push_back(row);
  endfunction

  // Wait drawn per item by either side; zero throughout a burst stretch.
  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 12);
  endfunction

  // Random items lean toward well-formed traffic on one task: mostly in-range
  // signals and the task's own evolving mask, with noise mixed in.
  function automatic sig_item_t random_item();
    sig_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 18)      it.op = spd_pkg::OP_REGISTER;
    else if (r < 30) it.op = spd_pkg::OP_LOOKUP;
    else if (r < 52) it.op = spd_pkg::OP_RAISE;
    else if (r < 72) it.op = spd_pkg::OP_CHECK;
    else if (r < 97) it.op = spd_pkg::OP_DELIVER;
    else             it.op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));

    r = $urandom_range(0, 99);
    if (r < 8)       it.sn = spd_pkg::SnW'($urandom_range(spd_pkg::SignalCount, 127));
    else if (r < 11) it.sn = spd_pkg::SnW'(spd_pkg::SigKill);
    else if (r < 14) it.sn = spd_pkg::SnW'(spd_pkg::SigStop);
    else if (r < 20) it.sn = spd_pkg::SnW'(spd_pkg::SigChld);
    else             it.sn = spd_pkg::SnW'($urandom_range(0, spd_pkg::SignalCount - 1));

    r = $urandom_range(0, 99);
    if (r < 20)      it.haddr = '0;
    else if (r < 25) it.haddr = '1;
    else             it.haddr = {$urandom, $urandom};

    it.ign = ($urandom_range(0, 3) == 0);

    r = $urandom_range(0, 99);
    if (r < 60)      it.pend = chain_mask;
    else if (r < 75) it.pend = {$urandom, $urandom};
    else if (r < 85) it.pend = (64'd1 << $urandom_range(0, 31))
                             | (64'd1 << $urandom_range(0, 31));
    else if (r < 90) it.pend = '0;
    else if (r < 95) it.pend = '1;
    else             it.pend = chain_mask | (64'd1 << $urandom_range(0, 63));
    return it;
  endfunction

  // Offers one item after a random gap and holds it until the block takes it.
  // The prediction is made at the accepting edge so that table updates follow
  // the order in which the block sees the items.
  task automatic send_item(input sig_item_t it, input bit known, input sig_result_t want);
    int gap;
    sig_result_t pred;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, it.pend, it.ign, it.haddr, it.sn, it.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = dispatch_outcome(it);
    outcome_q.push_back(known ? want : pred);
    chain_mask = pred.pend;
    items_sent++;
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: stalls for a randomly drawn wait before each item, then takes
  // it and compares every field with the oldest expected result.
  initial begin
    int stall;
    sig_result_t got;
    sig_result_t want;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.code  = out_tdata[2:0];
      got.pend  = out_tdata[66:3];
      got.hout  = out_tdata[130:67];
      got.ign   = out_tdata[131];
      got.ready = out_tdata[132];
      got.taken = out_tdata[138:133];
      results_seen++;
      code_hist[got.code]++;
      if (outcome_q.size() == 0) begin
        $display("%0t ns: unrequested result, expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        report_field("result_code", 64'(want.code), 64'(got.code));
        report_field("pending_out", want.pend, got.pend);
        report_field("handler_out", want.hout, got.hout);
        report_field("ignored_out", 64'(want.ign), 64'(got.ign));
        report_field("signal_ready", 64'(want.ready), 64'(got.ready));
        report_field("signal_taken", 64'(want.taken), 64'(got.taken));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    sig_has_handler = '0;
    sig_ignored = '0;
    foreach (code_hist[i]) code_hist[i] = 0;

    // Directed rows. The first group has results that follow from reset and
    // from the error rules alone, so they are typed in.
    add_row(spd_pkg::OP_LOOKUP, 7'd5, '0, 1'b0, '0, 1'b1, spd_pkg::RC_OK, '0);
    add_row(spd_pkg::OP_REGISTER, 7'd64, '1, 1'b1, '1, 1'b1, spd_pkg::RC_RANGE, '1);
    add_row(spd_pkg::OP_REGISTER, 7'd127, 64'h1234, 1'b0, '0, 1'b1,
            spd_pkg::RC_RANGE, '0);
    add_row(spd_pkg::OP_REGISTER, spd_pkg::SnW'(spd_pkg::SigKill), 64'hdead, 1'b1, '0,
            1'b1, spd_pkg::RC_KILLSTOP, '0);
    add_row(spd_pkg::OP_REGISTER, spd_pkg::SnW'(spd_pkg::SigStop), 64'hbeef, 1'b0,
            64'h5555_5555_5555_5555, 1'b1,
            spd_pkg::RC_KILLSTOP, 64'h5555_5555_5555_5555);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, '0, 1'b1, spd_pkg::RC_NONE, '0);
    add_row(spd_pkg::OP_CHECK, 7'd0, '0, 1'b0, '0, 1'b1, spd_pkg::RC_NONE, '0);
    add_row(OpUnusedLo, 7'd3, '1, 1'b1, '1, 1'b1, spd_pkg::RC_RANGE, '1);
    add_row(OpUnusedHi, 7'd0, '0, 1'b0, 64'hf0, 1'b1, spd_pkg::RC_RANGE, 64'hf0);
    add_row(spd_pkg::OP_RAISE, 7'd63, '0, 1'b0, '0, 1'b1, spd_pkg::RC_OK,
            64'h8000_0000_0000_0000);
    add_row(spd_pkg::OP_RAISE, 7'd0, '0, 1'b0, 64'h8000_0000_0000_0000, 1'b1,
            spd_pkg::RC_OK, 64'h8000_0000_0000_0001);
    add_row(spd_pkg::OP_RAISE, 7'd100, '0, 1'b0, '0, 1'b1, spd_pkg::RC_RANGE, '0);
    add_row(spd_pkg::OP_LOOKUP, 7'd64, '0, 1'b0, '0, 1'b1, spd_pkg::RC_RANGE, '0);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, 64'h8000_0000_0000_0000, 1'b1,
            spd_pkg::RC_TERM, '0, 6'd63);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, 64'h800, 1'b1,
            spd_pkg::RC_TERM_CORE, '0, 6'd11);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, '1, 1'b1, spd_pkg::RC_TERM,
            64'hffff_ffff_ffff_fffe, 6'd0);
    // Handlers, the one-shot rule and the ignore rules, checked by prediction.
    add_row(spd_pkg::OP_REGISTER, 7'd0, '1, 1'b0, '0);
    add_row(spd_pkg::OP_REGISTER, 7'd63, 64'd1, 1'b0, '0);
    add_row(spd_pkg::OP_LOOKUP, 7'd0, '0, 1'b0, '0);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, 64'd1);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, 64'd1);
    add_row(spd_pkg::OP_REGISTER, spd_pkg::SnW'(spd_pkg::SigChld), '0, 1'b1, '0);
    add_row(spd_pkg::OP_REGISTER, 7'd3, 64'h4000, 1'b1, '0);
    // Ignored signal 3 is dropped, then the ignored child signal ends the walk.
    add_row(spd_pkg::OP_CHECK, 7'd0, '0, 1'b0, 64'h0012_0008);
    add_row(spd_pkg::OP_CHECK, 7'd0, '0, 1'b0, 64'h0010_0008);
    add_row(spd_pkg::OP_CHECK, 7'd0, '0, 1'b0, 64'h8);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, 64'h8);
    add_row(spd_pkg::OP_LOOKUP, 7'd3, '0, 1'b0, '0);
    add_row(spd_pkg::OP_DELIVER, 7'd0, '0, 1'b0, 64'h8000_0000_0000_0000);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // Halfway through, hold the input side until the block has emptied.
      if (n == DrainAfter) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
      send_item(random_item(), 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d items (%0d directed), compared %0d results, %0d mismatching fields.",
             items_sent, dir_rows.size(), results_seen, mismatches);
    $display("Codes: ok %0d range %0d killstop %0d none %0d ign %0d hdl %0d term %0d core %0d",
             code_hist[spd_pkg::RC_OK], code_hist[spd_pkg::RC_RANGE],
             code_hist[spd_pkg::RC_KILLSTOP], code_hist[spd_pkg::RC_NONE],
             code_hist[spd_pkg::RC_IGNORED], code_hist[spd_pkg::RC_HANDLER],
             code_hist[spd_pkg::RC_TERM], code_hist[spd_pkg::RC_TERM_CORE]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
